>>> hw/rtl/merge_collinear_line_runs_unit_assert.svh
// ---------------------------------------------------------------------------
// merge_collinear_line_runs_unit assertion macros
// Concurrent assertion wrappers; they compile to nothing under SYNTHESIS.
// ---------------------------------------------------------------------------
`ifndef MERGE_COLLINEAR_LINE_RUNS_UNIT_ASSERT_SVH
`define MERGE_COLLINEAR_LINE_RUNS_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// property p must hold at every clock edge outside reset
`define MCL_ASSERT(lbl, clk, rst_n, p, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) p) else $error(msg);
// expression e must never be true outside reset
`define MCL_NEVER(lbl, clk, rst_n, e, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(e)) else $error(msg);
`else
`define MCL_ASSERT(lbl, clk, rst_n, p, msg)
`define MCL_NEVER(lbl, clk, rst_n, e, msg)
`endif
`endif

>>> hw/rtl/mcl_pkg.sv
// ---------------------------------------------------------------------------
// mcl_pkg
// Widths, codes and controller/datapath interface types of the run merger.
// ---------------------------------------------------------------------------
package mcl_pkg;

	localparam int COORD_BITS  = 20;
	localparam int INT_BITS    = 8;
	localparam int DIFF_BITS   = COORD_BITS + 1;
	localparam int PROD_BITS   = 2 * DIFF_BITS + 1;
	localparam int TDATA_BITS  = ((4 * COORD_BITS + INT_BITS + 7) / 8) * 8;

	// wide multiplier: A of three limbs, B of two limbs, one limb pair a cycle
	localparam int LIMB        = 32;
	localparam int A_LIMBS     = 3;
	localparam int B_LIMBS     = 2;
	localparam int A_BITS      = A_LIMBS * LIMB;
	localparam int B_BITS      = B_LIMBS * LIMB;
	localparam int WIDE_BITS   = 128;
	localparam int LIMB_STEPS  = A_LIMBS * B_LIMBS;
	localparam int LIMB_BITS   = $clog2(LIMB_STEPS);

	localparam int NUM_STEPS   = 19;
	localparam int STEP_BITS   = $clog2(NUM_STEPS);
	localparam int NUM_JOBS    = 6;
	localparam int JOB_BITS    = $clog2(NUM_JOBS);
	localparam int NUM_ACC     = 11;
	localparam int ACC_BITS    = $clog2(NUM_ACC);

	localparam int GAP_BITS    = 19;
	localparam int COS_BITS    = 16;
	localparam int COS_SHIFT   = 14;
	localparam logic signed [COS_BITS-1:0] COS_RESET = 16'sd16384;

	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 19;
	localparam logic [CFG_IDX_BITS-1:0] REG_BSTEP  = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_ABSORB = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_GAP    = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_PERP   = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_COS    = 3'd4;

	typedef struct packed {
		logic                 capture;
		logic                 prod_en;
		logic [STEP_BITS-1:0] step;
		logic                 wide_en;
		logic [JOB_BITS-1:0]  job;
		logic [LIMB_BITS-1:0] limb;
		logic                 decide;
		logic                 emit;
		logic                 emit_final;
		logic                 apply;
	} mcl_cmd_t;

	typedef struct packed {
		logic acc_valid;
		logic fin;
		logic merge_ok;
		logic out_free;
	} mcl_sts_t;

	function automatic logic signed [DIFF_BITS-1:0] sdiff(
		input logic signed [COORD_BITS-1:0] p,
		input logic signed [COORD_BITS-1:0] q
	);
		sdiff = DIFF_BITS'(p) - DIFF_BITS'(q);
	endfunction

	function automatic logic [PROD_BITS-1:0] mag(input logic signed [PROD_BITS-1:0] v);
		mag = v[PROD_BITS-1] ? PROD_BITS'(-v) : PROD_BITS'(v);
	endfunction

endpackage

>>> hw/rtl/mcl_dpath.sv
// ---------------------------------------------------------------------------
// mcl_dpath
// Run registers, small product accumulator, limb-serial wide multiplier,
// merge decision and output register.
// ---------------------------------------------------------------------------
module mcl_dpath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  mcl_pkg::mcl_cmd_t                cmd,
	output mcl_pkg::mcl_sts_t                sts,
	input  logic                             cfg_we,
	input  logic [mcl_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [mcl_pkg::CFG_DATA_BITS-1:0] cfg_data,
	input  logic [mcl_pkg::TDATA_BITS-1:0]   in_data,
	input  logic                             in_last,
	output logic [mcl_pkg::TDATA_BITS-1:0]   out_data,
	output logic                             out_last,
	output logic                             out_valid,
	input  logic                             out_ready
);
	import mcl_pkg::*;

	localparam logic [ACC_BITS-1:0] ACC_L   = 4'd0;
	localparam logic [ACC_BITS-1:0] ACC_C1  = 4'd1;
	localparam logic [ACC_BITS-1:0] ACC_P1  = 4'd2;
	localparam logic [ACC_BITS-1:0] ACC_C2  = 4'd3;
	localparam logic [ACC_BITS-1:0] ACC_P2  = 4'd4;
	localparam logic [ACC_BITS-1:0] ACC_G2  = 4'd5;
	localparam logic [ACC_BITS-1:0] ACC_D   = 4'd6;
	localparam logic [ACC_BITS-1:0] ACC_NL2 = 4'd7;
	localparam logic [ACC_BITS-1:0] ACC_GM2 = 4'd8;
	localparam logic [ACC_BITS-1:0] ACC_MM2 = 4'd9;
	localparam logic [ACC_BITS-1:0] ACC_CC  = 4'd10;

	localparam logic [1:0] MODE_HOLD = 2'd0;
	localparam logic [1:0] MODE_ADD  = 2'd1;
	localparam logic [1:0] MODE_SUB  = 2'd2;
	localparam logic [1:0] MODE_PUT  = 2'd3;

	// configuration
	logic [INT_BITS-1:0]        bstep_q;
	logic                       absorb_q;
	logic [GAP_BITS-1:0]        gap_q;
	logic [GAP_BITS-1:0]        perp_q;
	logic signed [COS_BITS-1:0] cos_q;

	// captured segment
	logic signed [COORD_BITS-1:0] seg_sx_q, seg_sy_q, seg_ex_q, seg_ey_q;
	logic [INT_BITS-1:0]          seg_int_q;
	logic                         seg_fin_q;

	// held run
	logic signed [COORD_BITS-1:0] acc_sx_q, acc_sy_q, acc_ex_q, acc_ey_q;
	logic [INT_BITS-1:0]          acc_int_q;
	logic                         acc_valid_q;

	logic signed [PROD_BITS-1:0] run_q;
	logic signed [PROD_BITS-1:0] pr_q [NUM_ACC];
	logic [WIDE_BITS-1:0]        wacc_q;
	logic [WIDE_BITS-1:0]        w_q [NUM_JOBS];
	logic                        merge_q;

	logic [TDATA_BITS-1:0] out_data_q;
	logic                  out_last_q;
	logic                  out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bstep_q  <= '0;
			absorb_q <= 1'b0;
			gap_q    <= '0;
			perp_q   <= '0;
			cos_q    <= COS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BSTEP:  bstep_q  <= cfg_data[INT_BITS-1:0];
				REG_ABSORB: absorb_q <= cfg_data[0];
				REG_GAP:    gap_q    <= cfg_data[GAP_BITS-1:0];
				REG_PERP:   perp_q   <= cfg_data[GAP_BITS-1:0];
				REG_COS:    cos_q    <= cfg_data[COS_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			seg_sx_q  <= in_data[0 +: COORD_BITS];
			seg_sy_q  <= in_data[COORD_BITS +: COORD_BITS];
			seg_ex_q  <= in_data[2*COORD_BITS +: COORD_BITS];
			seg_ey_q  <= in_data[3*COORD_BITS +: COORD_BITS];
			seg_int_q <= in_data[4*COORD_BITS +: INT_BITS];
			seg_fin_q <= in_last;
		end
	end

	// difference vectors
	logic signed [DIFF_BITS-1:0] ax, ay, nx, ny, dx, dy, v1x, v1y, v2x, v2y, gx, gy;
	logic acc_dot, seg_dot;

	always_comb begin
		ax  = sdiff(acc_ex_q, acc_sx_q);
		ay  = sdiff(acc_ey_q, acc_sy_q);
		nx  = sdiff(seg_ex_q, seg_sx_q);
		ny  = sdiff(seg_ey_q, seg_sy_q);
		acc_dot = (ax == '0) && (ay == '0);
		seg_dot = (nx == '0) && (ny == '0);
		v2x = sdiff(seg_ex_q, acc_sx_q);
		v2y = sdiff(seg_ey_q, acc_sy_q);
		// a dot run is tested against the segment's line instead
		if (acc_dot) begin
			dx  = nx;
			dy  = ny;
			v1x = sdiff(acc_sx_q, seg_sx_q);
			v1y = sdiff(acc_sy_q, seg_sy_q);
			gx  = sdiff(seg_sx_q, acc_sx_q);
			gy  = sdiff(seg_sy_q, acc_sy_q);
		end else begin
			dx  = ax;
			dy  = ay;
			v1x = sdiff(seg_sx_q, acc_sx_q);
			v1y = sdiff(seg_sy_q, acc_sy_q);
			gx  = sdiff(seg_sx_q, acc_ex_q);
			gy  = sdiff(seg_sy_q, acc_ey_q);
		end
	end

	// small product sequence: one signed multiply a cycle
	logic signed [DIFF_BITS-1:0]   op_a, op_b;
	logic [ACC_BITS-1:0]           dst;
	logic [1:0]                    mode;
	logic signed [2*DIFF_BITS-1:0] sp;
	logic signed [PROD_BITS-1:0]   spx;

	always_comb begin
		op_a = dx;
		op_b = dx;
		dst  = ACC_L;
		mode = MODE_HOLD;
		case (cmd.step)
			5'd0:  begin op_a = dx;  op_b = dx;  end
			5'd1:  begin op_a = dy;  op_b = dy;  dst = ACC_L;   mode = MODE_ADD; end
			5'd2:  begin op_a = dx;  op_b = v1y; end
			5'd3:  begin op_a = dy;  op_b = v1x; dst = ACC_C1;  mode = MODE_SUB; end
			5'd4:  begin op_a = v1x; op_b = dx;  end
			5'd5:  begin op_a = v1y; op_b = dy;  dst = ACC_P1;  mode = MODE_ADD; end
			5'd6:  begin op_a = ax;  op_b = v2y; end
			5'd7:  begin op_a = ay;  op_b = v2x; dst = ACC_C2;  mode = MODE_SUB; end
			5'd8:  begin op_a = v2x; op_b = ax;  end
			5'd9:  begin op_a = v2y; op_b = ay;  dst = ACC_P2;  mode = MODE_ADD; end
			5'd10: begin op_a = gx;  op_b = gx;  end
			5'd11: begin op_a = gy;  op_b = gy;  dst = ACC_G2;  mode = MODE_ADD; end
			5'd12: begin op_a = ax;  op_b = nx;  end
			5'd13: begin op_a = ay;  op_b = ny;  dst = ACC_D;   mode = MODE_ADD; end
			5'd14: begin op_a = nx;  op_b = nx;  end
			5'd15: begin op_a = ny;  op_b = ny;  dst = ACC_NL2; mode = MODE_ADD; end
			5'd16: begin
				op_a = $signed(DIFF_BITS'(gap_q));
				op_b = $signed(DIFF_BITS'(gap_q));
				dst  = ACC_GM2;
				mode = MODE_PUT;
			end
			5'd17: begin
				op_a = $signed(DIFF_BITS'(perp_q));
				op_b = $signed(DIFF_BITS'(perp_q));
				dst  = ACC_MM2;
				mode = MODE_PUT;
			end
			5'd18: begin
				op_a = DIFF_BITS'(cos_q);
				op_b = DIFF_BITS'(cos_q);
				dst  = ACC_CC;
				mode = MODE_PUT;
			end
			default: ;
		endcase
		sp  = op_a * op_b;
		spx = PROD_BITS'(sp);
	end

	always_ff @(posedge clk) begin
		if (cmd.prod_en) begin
			case (mode)
				MODE_HOLD: run_q      <= spx;
				MODE_ADD:  pr_q[dst]  <= run_q + spx;
				MODE_SUB:  pr_q[dst]  <= run_q - spx;
				default:   pr_q[dst]  <= spx;
			endcase
		end
	end

	// wide products, one 32x32 limb product a cycle
	logic [A_BITS-1:0]     wa;
	logic [B_BITS-1:0]     wb;
	logic [1:0]            li, lk;
	logic                  lj;
	logic [LIMB-1:0]       a_limb, b_limb;
	logic [2*LIMB-1:0]     pp;
	logic [WIDE_BITS-1:0]  shifted, wsum;

	always_comb begin
		case (cmd.job)
			3'd0: begin wa = A_BITS'(mag(pr_q[ACC_C1])); wb = B_BITS'(mag(pr_q[ACC_C1])); end
			3'd1: begin
				wa = A_BITS'($unsigned(pr_q[ACC_MM2]));
				wb = B_BITS'($unsigned(pr_q[ACC_L]));
			end
			3'd2: begin wa = A_BITS'(mag(pr_q[ACC_C2])); wb = B_BITS'(mag(pr_q[ACC_C2])); end
			3'd3: begin
				wa = A_BITS'($unsigned(pr_q[ACC_CC]));
				wb = B_BITS'($unsigned(pr_q[ACC_L]));
			end
			3'd4: begin
				wa = w_q[3][A_BITS-1:0];
				wb = B_BITS'($unsigned(pr_q[ACC_NL2]));
			end
			default: begin wa = A_BITS'(mag(pr_q[ACC_D])); wb = B_BITS'(mag(pr_q[ACC_D])); end
		endcase
		li = cmd.limb[2:1];
		lj = cmd.limb[0];
		lk = li + 2'(lj);
		case (li)
			2'd0:    a_limb = wa[LIMB-1:0];
			2'd1:    a_limb = wa[2*LIMB-1:LIMB];
			2'd2:    a_limb = wa[3*LIMB-1:2*LIMB];
			default: a_limb = '0;
		endcase
		b_limb = lj ? wb[2*LIMB-1:LIMB] : wb[LIMB-1:0];
		pp = a_limb * b_limb;
		case (lk)
			2'd0:    shifted = WIDE_BITS'(pp);
			2'd1:    shifted = WIDE_BITS'(pp) << LIMB;
			2'd2:    shifted = WIDE_BITS'(pp) << (2 * LIMB);
			default: shifted = WIDE_BITS'(pp) << (3 * LIMB);
		endcase
		wsum = ((cmd.limb == '0) ? '0 : wacc_q) + shifted;
	end

	always_ff @(posedge clk) begin
		if (cmd.wide_en) begin
			wacc_q <= wsum;
			if (cmd.limb == LIMB_BITS'(LIMB_STEPS - 1)) w_q[cmd.job] <= wsum;
		end
	end

	// merge decision
	logic [INT_BITS-1:0]  bdiff;
	logic [WIDE_BITS-1:0] dsc;
	logic b_fail, gap_fail, off1_fail, off2_fail, angle_fail, merge_d;
	logic signed [PROD_BITS-1:0] dval;

	always_comb begin
		bdiff     = (acc_int_q > seg_int_q) ? acc_int_q - seg_int_q : seg_int_q - acc_int_q;
		b_fail    = bdiff > bstep_q;
		gap_fail  = pr_q[ACC_G2] > pr_q[ACC_GM2];
		off1_fail = w_q[1] < w_q[0];
		off2_fail = w_q[1] < w_q[2];
		dval      = pr_q[ACC_D];
		dsc       = w_q[5] << (2 * COS_SHIFT);
		if (cos_q > 0)       angle_fail = (dval <= 0) || (dsc < w_q[4]);
		else if (cos_q == 0) angle_fail = dval < 0;
		else                 angle_fail = (dval < 0) && (w_q[4] < dsc);

		if (b_fail)                               merge_d = 1'b0;
		else if (acc_dot && seg_dot)              merge_d = 1'b0;
		else if ((acc_dot || seg_dot) && !absorb_q) merge_d = 1'b0;
		else if (acc_dot)
			merge_d = !gap_fail && !off1_fail && !(pr_q[ACC_P1] > 0);
		else if (seg_dot)
			merge_d = !gap_fail && !off1_fail && !(pr_q[ACC_P1] < pr_q[ACC_L]);
		else
			merge_d = !angle_fail && !gap_fail && !off1_fail && !off2_fail
				&& !(pr_q[ACC_P2] < pr_q[ACC_L]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			merge_q <= 1'b0;
		end else if (cmd.decide) begin
			merge_q <= merge_d;
		end
	end

	// run state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_sx_q    <= '0;
			acc_sy_q    <= '0;
			acc_ex_q    <= '0;
			acc_ey_q    <= '0;
			acc_int_q   <= '0;
			acc_valid_q <= 1'b0;
		end else if (cmd.apply) begin
			if (acc_valid_q && merge_q) begin
				acc_ex_q <= seg_ex_q;
				acc_ey_q <= seg_ey_q;
				if (seg_int_q > acc_int_q) acc_int_q <= seg_int_q;
			end else begin
				acc_sx_q    <= seg_sx_q;
				acc_sy_q    <= seg_sy_q;
				acc_ex_q    <= seg_ex_q;
				acc_ey_q    <= seg_ey_q;
				acc_int_q   <= seg_int_q;
				acc_valid_q <= 1'b1;
			end
		end else if (cmd.emit_final) begin
			acc_valid_q <= 1'b0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit || cmd.emit_final) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit || cmd.emit_final) begin
			out_data_q <= TDATA_BITS'({acc_int_q, acc_ey_q, acc_ex_q, acc_sy_q, acc_sx_q});
			out_last_q <= cmd.emit_final;
		end
	end

	assign out_data  = out_data_q;
	assign out_last  = out_last_q;
	assign out_valid = out_valid_q;

	assign sts.acc_valid = acc_valid_q;
	assign sts.fin       = seg_fin_q;
	assign sts.merge_ok  = merge_q;
	assign sts.out_free  = !out_valid_q || out_ready;

endmodule

>>> hw/rtl/mcl_ctrl.sv
// ---------------------------------------------------------------------------
// mcl_ctrl
// Sequencer: capture, product steps, wide limb steps, decision, emit, update.
// ---------------------------------------------------------------------------
`include "merge_collinear_line_runs_unit_assert.svh"

module mcl_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  mcl_pkg::mcl_sts_t sts,
	output mcl_pkg::mcl_cmd_t cmd
);
	import mcl_pkg::*;

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_PROD     = 3'd1;
	localparam logic [2:0] ST_WIDE     = 3'd2;
	localparam logic [2:0] ST_DECIDE   = 3'd3;
	localparam logic [2:0] ST_EMIT_OLD = 3'd4;
	localparam logic [2:0] ST_APPLY    = 3'd5;
	localparam logic [2:0] ST_EMIT_FIN = 3'd6;

	logic [2:0]           state_q, state_d;
	logic [STEP_BITS-1:0] step_q, step_d;
	logic [JOB_BITS-1:0]  job_q, job_d;
	logic [LIMB_BITS-1:0] limb_q, limb_d;

	always_comb begin
		state_d  = state_q;
		step_d   = step_q;
		job_d    = job_q;
		limb_d   = limb_q;
		cmd      = '0;
		cmd.step = step_q;
		cmd.job  = job_q;
		cmd.limb = limb_q;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = sts.acc_valid ? ST_PROD : ST_APPLY;
				end
			end
			ST_PROD: begin
				cmd.prod_en = 1'b1;
				if (step_q == STEP_BITS'(NUM_STEPS - 1)) begin
					step_d  = '0;
					state_d = ST_WIDE;
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			ST_WIDE: begin
				cmd.wide_en = 1'b1;
				if (limb_q == LIMB_BITS'(LIMB_STEPS - 1)) begin
					limb_d = '0;
					if (job_q == JOB_BITS'(NUM_JOBS - 1)) begin
						job_d   = '0;
						state_d = ST_DECIDE;
					end else begin
						job_d = job_q + 1'b1;
					end
				end else begin
					limb_d = limb_q + 1'b1;
				end
			end
			ST_DECIDE: begin
				cmd.decide = 1'b1;
				state_d = ST_EMIT_OLD;
			end
			ST_EMIT_OLD: begin
				// a rejected segment pushes the held run out first
				if (sts.merge_ok) begin
					state_d = ST_APPLY;
				end else if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d = ST_APPLY;
				end
			end
			ST_APPLY: begin
				cmd.apply = 1'b1;
				state_d = sts.fin ? ST_EMIT_FIN : ST_IDLE;
			end
			ST_EMIT_FIN: begin
				if (sts.out_free) begin
					cmd.emit_final = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			job_q   <= '0;
			limb_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			job_q   <= job_d;
			limb_q  <= limb_d;
		end
	end

	`MCL_ASSERT(a_decide_after_wide, clk, arst_n, (state_q == ST_DECIDE) |-> ($past(state_q) == ST_WIDE), "decide entered before wide products finished")
	`MCL_ASSERT(a_prod_needs_run, clk, arst_n, (state_q == ST_PROD) |-> sts.acc_valid, "merge test running with no held run")
	`MCL_ASSERT(a_flush_on_last, clk, arst_n, (state_q == ST_EMIT_FIN) |-> sts.fin, "flush without a last segment")
	`MCL_NEVER(a_no_overrun, clk, arst_n, (cmd.emit || cmd.emit_final) && !sts.out_free, "output word overwritten")

endmodule

>>> hw/rtl/merge_collinear_line_runs_unit.sv
// ---------------------------------------------------------------------------
// merge_collinear_line_runs_unit
// Welds a stream of line segments into longer collinear runs.
// ---------------------------------------------------------------------------
// Segments come in on s_axis; tlast marks the last segment of a list.
// Merged runs leave on m_axis; tlast marks the run flushed by the last segment.
// Each segment yields zero, one or two run words.
// cfg_* writes the five limits; cfg_ready is always high. Write only while idle.
// A segment that arrives with no run held goes straight to update (and final emit if last).
// With a run held the merge test runs 19 steps of one 21x21 signed
// multiplier for the dot, cross and squared-limit products, then 36 steps of one
// 32x32 multiplier building the six wide products, limb by limb, then decide,
// emit of the held run if rejected, and update; a last segment adds the final emit.
// s_axis_tready is high only between segments.
// The output word sits in a register; a stalled receiver holds it and the
// block waits only when it must emit another word.
// Reset clears the held run and restores the limits to their reset values.
// ---------------------------------------------------------------------------
module merge_collinear_line_runs_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// start_x, start_y, end_x, end_y, intensity
	input  logic [mcl_pkg::TDATA_BITS-1:0]    s_axis_tdata,
	input  logic                              s_axis_tlast,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// run_start_x, run_start_y, run_end_x, run_end_y, run_intensity
	output logic [mcl_pkg::TDATA_BITS-1:0]    m_axis_tdata,
	output logic                              m_axis_tlast,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [mcl_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [mcl_pkg::CFG_DATA_BITS-1:0] cfg_data
);
	import mcl_pkg::*;

	mcl_cmd_t cmd;
	mcl_sts_t sts;

	assign cfg_ready = 1'b1;

	mcl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mcl_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (s_axis_tdata),
		.in_last   (s_axis_tlast),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready)
	);

endmodule

>>> tb/merge_collinear_line_runs_unit_test.sv
// ---------------------------------------------------------------------------
// merge_collinear_line_runs_unit_test
// Streams line segments through the run merger and checks every run word
// against an exact wide-integer predictor, across several limit settings
// and with random gaps and stalls on both streams.
// ---------------------------------------------------------------------------
module merge_collinear_line_runs_unit_test;
	import mcl_pkg::*;

	localparam int CLK_HALF    = 6;
	localparam int IDLE_LIMIT  = 6000;
	localparam int DRAIN_WAIT  = 80;
	localparam int HOLD_CYCLES = 900;
	localparam int HOLD_PHASE  = 3;
	localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 3'd7;

	typedef logic signed [255:0] wide_t;

	typedef struct {
		logic signed [COORD_BITS-1:0] sx, sy, ex, ey;
		logic [INT_BITS-1:0]          bright;
		logic                         last;
	} seg_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [TDATA_BITS-1:0] s_axis_tdata = '0;
	logic s_axis_tlast = 0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [TDATA_BITS-1:0] m_axis_tdata;
	logic m_axis_tlast;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;

	merge_collinear_line_runs_unit dut (
		.clk, .arst_n,
		.s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
		.m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data
	);

	// limits as the block should hold them
	logic [7:0]  lim_bstep  = 0;
	logic        lim_absorb = 0;
	logic [18:0] lim_gap    = 0;
	logic [18:0] lim_perp   = 0;
	logic signed [15:0] lim_cos = COS_RESET;

	// run held by the predictor
	wide_t      run_sx, run_sy, run_ex, run_ey;
	logic [7:0] run_bright = 0;
	logic       run_held = 0;

	seg_t segs_pending[$];
	seg_t runs_expected[$];

	int send_idle = 0;
	int recv_stall = 0;
	int rx_hold = 0;
	int cur_phase = 0;
	bit hold_used = 0;
	int mismatches = 0;
	int runs_checked = 0;
	int finals_checked = 0;
	int merges_seen = 0;
	int segs_accepted = 0;
	int quiet_cycles = 0;

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	function automatic void queue_seg(seg_t s);
		segs_pending.insert(segs_pending.size(), s);
	endfunction

	function automatic void expect_run(seg_t r);
		runs_expected.insert(runs_expected.size(), r);
	endfunction

	function automatic wide_t dot2(wide_t ax, wide_t ay, wide_t bx, wide_t by);
		return ax * bx + ay * by;
	endfunction

	function automatic bit gap_over(wide_t dx, wide_t dy);
		wide_t g;
		g = wide_t'(lim_gap);
		return g * g < dot2(dx, dy, dx, dy);
	endfunction

	function automatic bit off_line(wide_t dx, wide_t dy, wide_t vx, wide_t vy);
		wide_t m, cr;
		m = wide_t'(lim_perp);
		cr = dx * vy - dy * vx;
		return m * m * dot2(dx, dy, dx, dy) < cr * cr;
	endfunction

	function automatic bit angle_over(wide_t ax, wide_t ay, wide_t nx, wide_t ny);
		wide_t d, c, lens, climit, dscaled;
		d = dot2(ax, ay, nx, ny);
		c = wide_t'(lim_cos);
		lens = dot2(ax, ay, ax, ay) * dot2(nx, ny, nx, ny);
		climit = c * c * lens;
		dscaled = (d * d) <<< (2 * COS_SHIFT);
		if (c > 0) begin
			if (d <= 0) return 1;
			return dscaled < climit;
		end
		if (c == 0) return d < 0;
		if (d >= 0) return 0;
		return climit < dscaled;
	endfunction

	function automatic bit can_join(seg_t s);
		wide_t sx, sy, ex, ey, ax, ay, nx, ny;
		int diff;
		bit run_dot, seg_dot;
		wide_t alen2;
		sx = wide_t'(s.sx); sy = wide_t'(s.sy); ex = wide_t'(s.ex); ey = wide_t'(s.ey);
		ax = run_ex - run_sx; ay = run_ey - run_sy;
		nx = ex - sx; ny = ey - sy;
		run_dot = (ax == 0 && ay == 0);
		seg_dot = (nx == 0 && ny == 0);
		diff = int'(run_bright) - int'(s.bright);
		if (diff < 0) diff = -diff;
		if (diff > int'(lim_bstep)) return 0;
		if (run_dot && seg_dot) return 0;
		if ((run_dot || seg_dot) && !lim_absorb) return 0;
		if (run_dot) begin
			if (gap_over(sx - run_sx, sy - run_sy)) return 0;
			if (off_line(nx, ny, run_sx - sx, run_sy - sy)) return 0;
			return dot2(run_sx - sx, run_sy - sy, nx, ny) <= 0;
		end
		alen2 = dot2(ax, ay, ax, ay);
		if (seg_dot) begin
			if (gap_over(sx - run_ex, sy - run_ey)) return 0;
			if (off_line(ax, ay, sx - run_sx, sy - run_sy)) return 0;
			return !(dot2(sx - run_sx, sy - run_sy, ax, ay) < alen2);
		end
		if (angle_over(ax, ay, nx, ny)) return 0;
		if (gap_over(sx - run_ex, sy - run_ey)) return 0;
		if (off_line(ax, ay, sx - run_sx, sy - run_sy)) return 0;
		if (off_line(ax, ay, ex - run_sx, ey - run_sy)) return 0;
		return !(dot2(ex - run_sx, ey - run_sy, ax, ay) < alen2);
	endfunction

	function automatic seg_t held_run(logic last);
		seg_t r;
		r.sx = COORD_BITS'(run_sx); r.sy = COORD_BITS'(run_sy);
		r.ex = COORD_BITS'(run_ex); r.ey = COORD_BITS'(run_ey);
		r.bright = run_bright; r.last = last;
		return r;
	endfunction

	function automatic void weld_segment(seg_t s);
		bit reload;
		reload = 1;
		if (run_held) begin
			if (can_join(s)) begin
				run_ex = wide_t'(s.ex); run_ey = wide_t'(s.ey);
				if (s.bright > run_bright) run_bright = s.bright;
				reload = 0;
				merges_seen++;
			end else begin
				expect_run(held_run(1'b0));
			end
		end
		if (reload) begin
			run_sx = wide_t'(s.sx); run_sy = wide_t'(s.sy);
			run_ex = wide_t'(s.ex); run_ey = wide_t'(s.ey);
			run_bright = s.bright;
			run_held = 1;
		end
		if (s.last) begin
			expect_run(held_run(1'b1));
			run_held = 0;
		end
	endfunction

	function automatic seg_t mk(int sx, int sy, int ex, int ey, int b, bit last);
		seg_t s;
		s.sx = COORD_BITS'(sx); s.sy = COORD_BITS'(sy);
		s.ex = COORD_BITS'(ex); s.ey = COORD_BITS'(ey);
		s.bright = INT_BITS'(b); s.last = last;
		return s;
	endfunction

	function automatic int srnd(int r);
		return int'($urandom_range(2 * r)) - r;
	endfunction

	function automatic seg_t noise_seg();
		seg_t s;
		s.sx = COORD_BITS'($urandom); s.sy = COORD_BITS'($urandom);
		s.ex = COORD_BITS'($urandom); s.ey = COORD_BITS'($urandom);
		s.bright = INT_BITS'($urandom); s.last = ($urandom_range(29) == 0);
		return s;
	endfunction

	// a collinear chain, roughly contiguous, with some dots and jitter
	task automatic add_chain(int n);
		int px, py, dx, dy, k, jit, b;
		seg_t s;
		px = srnd(200000); py = srnd(200000);
		do begin
			dx = srnd(2000); dy = srnd(2000);
		end while (dx == 0 && dy == 0);
		jit = $urandom_range(3) == 0 ? 4 : 0;
		b = int'($urandom_range(255));
		for (int i = 0; i < n; i++) begin
			s.sx = COORD_BITS'(px + srnd(jit)); s.sy = COORD_BITS'(py + srnd(jit));
			k = int'($urandom_range(1, 3));
			if ($urandom_range(7) == 0) begin
				s.ex = s.sx; s.ey = s.sy;
			end else begin
				s.ex = COORD_BITS'(px + k * dx + srnd(jit));
				s.ey = COORD_BITS'(py + k * dy + srnd(jit));
			end
			if ($urandom_range(11) == 0) begin
				s.ex = COORD_BITS'(px - k * dx); s.ey = COORD_BITS'(py - k * dy);
			end
			b = b + srnd(12);
			if (b < 0) b = 0;
			if (b > 255) b = 255;
			s.bright = INT_BITS'(b);
			s.last = ($urandom_range(39) == 0);
			queue_seg(s);
			px = int'(s.ex); py = int'(s.ey);
		end
	endtask

	task automatic fill_random(int count);
		int n;
		n = 0;
		while (n < count) begin
			if ($urandom_range(4) == 0) begin
				queue_seg(noise_seg());
				n++;
			end else begin
				int len;
				len = int'($urandom_range(2, 9));
				add_chain(len);
				n += len;
			end
		end
		segs_pending[$].last = 1;
	endtask

	// five limits in one burst, plus an optional write to an unused index
	task automatic write_limits(int bstep, int absorb, int gap, int perp, int cosv,
			bit stray);
		int vals[6];
		int top;
		vals = '{bstep, absorb, gap, perp, cosv, int'($urandom)};
		top = stray ? 6 : 5;
		@(posedge clk);
		for (int i = 0; i < top; i++) begin
			cfg_valid <= 1;
			cfg_index <= (i == 5) ? REG_UNUSED : CFG_IDX_BITS'(i);
			cfg_data <= CFG_DATA_BITS'(vals[i]);
			do @(posedge clk); while (!cfg_ready);
			case (i)
				0: lim_bstep = 8'(vals[i]);
				1: lim_absorb = vals[i][0];
				2: lim_gap = 19'(vals[i]);
				3: lim_perp = 19'(vals[i]);
				4: lim_cos = 16'(vals[i]);
				default: ;
			endcase
		end
		cfg_valid <= 0;
	endtask

	task automatic wait_drained();
		do @(posedge clk);
		while (segs_pending.size() != 0 || s_axis_tvalid || runs_expected.size() != 0);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// segment driver
	always @(posedge clk or negedge arst_n) begin
		seg_t s;
		if (!arst_n) begin
			s_axis_tvalid <= 0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (segs_pending.size() != 0 && $urandom_range(99) >= send_idle) begin
				s = segs_pending.pop_front();
				s_axis_tvalid <= 1;
				s_axis_tdata <= {s.bright, s.ey, s.ex, s.sy, s.sx};
				s_axis_tlast <= s.last;
			end else begin
				s_axis_tvalid <= 0;
			end
		end
	end

	// run receiver; one long stall in its phase, counted here
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 0;
		end else if (rx_hold > 0) begin
			m_axis_tready <= 0;
			rx_hold <= rx_hold - 1;
		end else if (cur_phase == HOLD_PHASE && !hold_used) begin
			m_axis_tready <= 0;
			rx_hold <= HOLD_CYCLES;
			hold_used <= 1;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall);
		end
	end

	// monitor: predict on accepted segments, check accepted run words
	always @(posedge clk) begin
		seg_t s, e;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				{s.bright, s.ey, s.ex, s.sy, s.sx} = s_axis_tdata[4*COORD_BITS+INT_BITS-1:0];
				s.last = s_axis_tlast;
				weld_segment(s);
				segs_accepted++;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				{s.bright, s.ey, s.ex, s.sy, s.sx} = m_axis_tdata[4*COORD_BITS+INT_BITS-1:0];
				s.last = m_axis_tlast;
				if (runs_expected.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected run word: %0d,%0d -> %0d,%0d b=%0d last=%0b",
							s.sx, s.sy, s.ex, s.ey, s.bright, s.last);
				end else begin
					e = runs_expected.pop_front();
					runs_checked++;
					if (e.last) finals_checked++;
					if (s.sx !== e.sx || s.sy !== e.sy || s.ex !== e.ex || s.ey !== e.ey
							|| s.bright !== e.bright || s.last !== e.last) begin
						mismatches++;
						if (mismatches <= 10) begin
							$write("run mismatch: exp %0d,%0d -> %0d,%0d b=%0d last=%0b",
								e.sx, e.sy, e.ex, e.ey, e.bright, e.last);
							$display(", got %0d,%0d -> %0d,%0d b=%0d last=%0b",
								s.sx, s.sy, s.ex, s.ey, s.bright, s.last);
						end
					end
				end
			end
		end
	end

	// watchdog on cycles with no word moving anywhere
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		int cfgs[6][5];
		cfgs = '{
			'{0, 0, 0, 0, 16384},
			'{255, 1, 524287, 524287, -16384},
			'{20, 1, 4000, 300, 15000},
			'{8, 0, 1000, 50, 16000},
			'{100, 1, 20000, 2000, 0},
			'{255, 1, 524287, 524287, -20000}
		};
		repeat (6) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// reset limits: only exact, contiguous, equal-brightness lines weld
		queue_seg(mk(0, 0, 100, 50, 7, 0));
		queue_seg(mk(100, 50, 300, 150, 7, 0));
		queue_seg(mk(300, 150, 400, 200, 8, 0));
		queue_seg(mk(-524288, -524288, 524287, 524287, 255, 0));
		queue_seg(mk(524287, -524288, -524288, 524287, 0, 1));
		queue_seg(mk(5, 5, 5, 5, 9, 1));
		wait_drained();

		for (int ph = 1; ph < 12; ph++) begin
			int c;
			c = ph % 6;
			write_limits(cfgs[c][0], cfgs[c][1], cfgs[c][2], cfgs[c][3],
				(ph == 11) ? 20000 : cfgs[c][4], c == 2);
			case (ph % 4)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 45; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 45; end
				default: begin send_idle = 21; recv_stall = 21; end
			endcase
			if (ph == 1) begin
				// dots, dot runs, backwards segment, extremes
				queue_seg(mk(0, 0, 0, 0, 10, 0));
				queue_seg(mk(0, 0, 1000, 0, 12, 0));
				queue_seg(mk(1000, 0, 1000, 0, 12, 0));
				queue_seg(mk(1000, 0, 1000, 0, 12, 0));
				queue_seg(mk(900, 0, 0, 0, 200, 0));
				queue_seg(mk(-524288, 524287, 524287, -524288, 0, 0));
				queue_seg(mk(524287, -524288, 524287, -524288, 255, 1));
				queue_seg(mk(3, 3, 3, 3, 1, 0));
				queue_seg(mk(3, 3, 3, 3, 1, 1));
			end
			fill_random(95);
			cur_phase = ph;
			wait_drained();
		end

		$display("segments accepted: %0d, run words checked: %0d (%0d final), merges: %0d",
			segs_accepted, runs_checked, finals_checked, merges_seen);
		$display("eleven limit settings incl. extremes, dots on and off, idle and stall mixes");
		if (mismatches == 0 && runs_expected.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
